### design/rfb_pkg.sv
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types and constants of the RS485 frame buffer with idle timeout.
// ----------------------------------------------------------------------------
package rfb_pkg;

	localparam int FUNC_W   = 3;
	localparam int BYTE_W   = 8;
	localparam int INDEX_W  = 7;
	localparam int LENGTH_W = 8;
	localparam int COUNT_W  = 8;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int INDEX_SPAN = 1 << INDEX_W;

	localparam logic [BYTE_W-1:0] IDLE_TICKS_RESET = 8'd5;

	// top address bit that selects the configuration register
	localparam logic [0:0] REG_RX_IDLE_TICKS = 1'b0;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK       = 3'd0,
		FN_TX_DONE    = 3'd1,
		FN_RX_BYTE    = 3'd2,
		FN_TX_WRITE   = 3'd3,
		FN_TX_START   = 3'd4,
		FN_RX_RELEASE = 3'd5,
		FN_RX_READ    = 3'd6
	} func_t;

	// status of one event, as seen after the event
	typedef struct packed {
		logic               tx_fire;
		logic               drive_enable;
		logic               frame_ready;
		logic [COUNT_W-1:0] rx_count;
		logic               rd_sel;
	} stat_t;

endpackage

### design/rfb_if.sv
// ----------------------------------------------------------------------------
// rfb_in_if / rfb_out_if
// Valid/ready channels carrying one event word and one result word.
// ----------------------------------------------------------------------------
interface rfb_in_if import rfb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [BYTE_W-1:0]   data;
	logic [INDEX_W-1:0]  index;
	logic [LENGTH_W-1:0] length;

	modport source (output valid, func, data, index, length, input ready);
	modport sink (input valid, func, data, index, length, output ready);
endinterface

interface rfb_out_if import rfb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               tx_valid;
	logic [BYTE_W-1:0]  tx_data;
	logic               drive_enable;
	logic               frame_ready;
	logic [COUNT_W-1:0] rx_count;
	logic [BYTE_W-1:0]  read_data;

	modport source (output valid, tx_valid, tx_data, drive_enable, frame_ready, rx_count,
		read_data, input ready);
	modport sink (input valid, tx_valid, tx_data, drive_enable, frame_ready, rx_count,
		read_data, output ready);
endinterface

### design/rs485_frame_buffer_idle_timeout_top.sv
// ----------------------------------------------------------------------------
// rs485_frame_buffer_idle_timeout_top
// RS485 frame engine: transmit and receive byte stores with idle framing.
// ----------------------------------------------------------------------------
// Results are registered, in the cycle after acceptance. Throughput: one event
// per cycle while the result slot is empty or taken; each event does at most
// one store access at accept; the result stage picks up its registered data.
// Reset: asynchronous, clears timer, counts, flags and result valid; the
// byte stores are not cleared, idle ticks register returns to 5.
module rs485_frame_buffer_idle_timeout_top import rfb_pkg::*; #(
	parameter int BUF_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	rfb_in_if.sink             req,
	rfb_out_if.source          rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int CW = $clog2(BUF_DEPTH + 1);

	logic              acc;
	logic              s1_valid_q;
	stat_t             stat, stat_s1;
	logic [BYTE_W-1:0] idle_q;
	logic              tx_we, tx_re, rx_we, rx_re;
	logic [AW-1:0]     tx_waddr, tx_raddr, rx_waddr, rx_raddr;
	logic [BYTE_W-1:0] tx_wdata, rx_wdata, tx_rdata, rx_rdata;
	logic              reg_hit;

	// configuration
	assign pready = 1'b1;
	assign reg_hit = paddr[PADDR_W-1] == REG_RX_IDLE_TICKS;
	assign prdata = reg_hit ? PDATA_W'(idle_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= IDLE_TICKS_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			idle_q <= pwdata[BYTE_W-1:0];
		end
	end

	// advance when the result slot is empty or being taken
	assign req.ready = !s1_valid_q || rsp.ready;
	assign acc = req.valid && req.ready;

	rfb_ctrl #(
		.BUF_DEPTH(BUF_DEPTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.acc(acc),
		.func(req.func),
		.data(req.data),
		.index(req.index),
		.length(req.length),
		.idle_ticks(idle_q),
		.tx_we(tx_we),
		.tx_waddr(tx_waddr),
		.tx_wdata(tx_wdata),
		.tx_re(tx_re),
		.tx_raddr(tx_raddr),
		.rx_we(rx_we),
		.rx_waddr(rx_waddr),
		.rx_wdata(rx_wdata),
		.rx_re(rx_re),
		.rx_raddr(rx_raddr),
		.stat(stat)
	);

	rfb_ram #(.DEPTH(BUF_DEPTH), .AW(AW), .DW(BYTE_W)) u_tx_ram (
		.clk(clk),
		.we(tx_we),
		.waddr(tx_waddr),
		.wdata(tx_wdata),
		.re(tx_re),
		.raddr(tx_raddr),
		.rdata(tx_rdata)
	);

	rfb_ram #(.DEPTH(BUF_DEPTH), .AW(AW), .DW(BYTE_W)) u_rx_ram (
		.clk(clk),
		.we(rx_we),
		.waddr(rx_waddr),
		.wdata(rx_wdata),
		.re(rx_re),
		.raddr(rx_raddr),
		.rdata(rx_rdata)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			stat_s1 <= stat;
		end
	end

	assign rsp.valid = s1_valid_q;
	assign rsp.tx_valid = stat_s1.tx_fire;
	assign rsp.tx_data = stat_s1.tx_fire ? tx_rdata : '0;
	assign rsp.drive_enable = stat_s1.drive_enable;
	assign rsp.frame_ready = stat_s1.frame_ready;
	assign rsp.rx_count = stat_s1.rx_count;
	assign rsp.read_data = stat_s1.rd_sel ? rx_rdata : '0;

	a_empty_send: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.func == FN_TX_START && req.length == '0
		|=> rsp.valid && !rsp.drive_enable && !rsp.tx_valid)
		else $error("empty send left the driver on or emitted a word");

	a_mem_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_re || rx_re || tx_we || rx_we) |-> acc)
		else $error("store access without an accepted word");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> s1_valid_q)
		else $error("accepted word produced no result");

endmodule

### design/rfb_ram.sv
// ----------------------------------------------------------------------------
// rfb_ram
// Byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rfb_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/rfb_ctrl.sv
// ----------------------------------------------------------------------------
// rfb_ctrl
// Event decoder and scalar state: transmit pointer, receive fill, idle timer.
// ----------------------------------------------------------------------------
module rfb_ctrl import rfb_pkg::*; #(
	parameter int BUF_DEPTH = 128,
	parameter int AW        = 7,
	parameter int CW        = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  logic [FUNC_W-1:0]   func,
	input  logic [BYTE_W-1:0]   data,
	input  logic [INDEX_W-1:0]  index,
	input  logic [LENGTH_W-1:0] length,
	input  logic [BYTE_W-1:0]   idle_ticks,
	output logic                tx_we,
	output logic [AW-1:0]       tx_waddr,
	output logic [BYTE_W-1:0]   tx_wdata,
	output logic                tx_re,
	output logic [AW-1:0]       tx_raddr,
	output logic                rx_we,
	output logic [AW-1:0]       rx_waddr,
	output logic [BYTE_W-1:0]   rx_wdata,
	output logic                rx_re,
	output logic [AW-1:0]       rx_raddr,
	output stat_t               stat
);

	logic [CW-1:0]     tx_rem_q, tx_rem_d;
	logic [CW-1:0]     tx_pos_q, tx_pos_d;
	logic [CW-1:0]     rx_fill_q, rx_fill_d;
	logic [BYTE_W-1:0] timer_q, timer_d;
	logic              frame_q, frame_d;
	logic              drv_q, drv_d;
	logic              tx_we_c, tx_re_c, rx_we_c, rx_re_c, fire_c, rd_sel_c;
	logic [CW-1:0]     len_sat;
	logic [8:0]        fill_ext;
	logic [AW-1:0]     wrap_tab [INDEX_SPAN];

	// index modulo buffer depth, worked out at elaboration
	for (genvar g = 0; g < INDEX_SPAN; g++) begin : g_wrap
		assign wrap_tab[g] = AW'(g % BUF_DEPTH);
	end

	assign len_sat = (9'(length) > 9'(BUF_DEPTH)) ? CW'(BUF_DEPTH) : CW'(length);

	always_comb begin
		tx_rem_d = tx_rem_q;
		tx_pos_d = tx_pos_q;
		rx_fill_d = rx_fill_q;
		timer_d = timer_q;
		frame_d = frame_q;
		drv_d = drv_q;
		tx_we_c = 1'b0;
		tx_re_c = 1'b0;
		rx_we_c = 1'b0;
		rx_re_c = 1'b0;
		fire_c = 1'b0;
		rd_sel_c = 1'b0;
		tx_raddr = tx_pos_q[AW-1:0];
		rx_waddr = rx_fill_q[AW-1:0];
		case (func_t'(func))
			FN_TICK: begin
				if (timer_q != '0) begin
					timer_d = timer_q - 1'b1;
					if (timer_q == 8'd1 && rx_fill_q != '0) begin
						frame_d = 1'b1;
					end
				end
			end
			FN_TX_DONE: begin
				if (tx_rem_q != '0) begin
					tx_re_c = 1'b1;
					fire_c = 1'b1;
					tx_pos_d = tx_pos_q + CW'(1);
					tx_rem_d = tx_rem_q - CW'(1);
				end else begin
					tx_pos_d = '0;
					drv_d = 1'b0;
				end
			end
			FN_RX_BYTE: begin
				if (!frame_q) begin
					rx_we_c = 1'b1;
					// restart at the front once the store is full
					if (rx_fill_q >= CW'(BUF_DEPTH)) begin
						rx_waddr = '0;
						rx_fill_d = CW'(1);
					end else begin
						rx_fill_d = rx_fill_q + CW'(1);
					end
				end
				timer_d = idle_ticks;
			end
			FN_TX_WRITE: begin
				tx_we_c = 1'b1;
			end
			FN_TX_START: begin
				tx_pos_d = '0;
				tx_rem_d = len_sat;
				drv_d = 1'b0;
				if (len_sat != '0) begin
					tx_re_c = 1'b1;
					fire_c = 1'b1;
					tx_raddr = '0;
					tx_pos_d = CW'(1);
					tx_rem_d = len_sat - CW'(1);
					drv_d = 1'b1;
				end
			end
			FN_RX_RELEASE: begin
				frame_d = 1'b0;
				rx_fill_d = '0;
			end
			FN_RX_READ: begin
				rx_re_c = 1'b1;
				rd_sel_c = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign tx_we = acc && tx_we_c;
	assign tx_re = acc && tx_re_c;
	assign rx_we = acc && rx_we_c;
	assign rx_re = acc && rx_re_c;
	assign tx_waddr = wrap_tab[index];
	assign tx_wdata = data;
	assign rx_wdata = data;
	assign rx_raddr = wrap_tab[index];

	assign fill_ext = 9'(rx_fill_d);
	assign stat.tx_fire = fire_c;
	assign stat.drive_enable = drv_d;
	assign stat.frame_ready = frame_d;
	assign stat.rx_count = fill_ext[7:0];
	assign stat.rd_sel = rd_sel_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_rem_q <= '0;
			tx_pos_q <= '0;
			rx_fill_q <= '0;
			timer_q <= '0;
			frame_q <= 1'b0;
			drv_q <= 1'b0;
		end else if (acc) begin
			tx_rem_q <= tx_rem_d;
			tx_pos_q <= tx_pos_d;
			rx_fill_q <= rx_fill_d;
			timer_q <= timer_d;
			frame_q <= frame_d;
			drv_q <= drv_d;
		end
	end

	a_frame_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q |-> rx_fill_q != '0)
		else $error("frame ready with empty receive store");

	a_send_drives: assert property (@(posedge clk) disable iff (!arst_n)
		tx_rem_q != '0 |-> drv_q)
		else $error("bytes pending while driver is off");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fill_q <= CW'(BUF_DEPTH) && tx_rem_q + tx_pos_q <= CW'(BUF_DEPTH))
		else $error("receive fill or transmit pointer beyond depth");

endmodule
